/* hw/rtl/d8fd_pkg.sv */
// Shared types, widths and constants of the D8 flow-direction stream.
package d8fd_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int ELEV_BITS = 24;

  localparam int ROW_W  = 13;
  localparam int COL_W  = 11;
  localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // drop between two samples, and drop scaled by the Q16 weight
  localparam int DROP_W  = ELEV_BITS + 1;
  localparam int SCALE_W = DROP_W + 17;

  localparam logic signed [17:0] DIAG_W     = 18'sd46341;
  localparam int                 ORTH_SHIFT = 16;

  localparam int                 COL_CAP   = (MAX_COLS > (2**COL_W - 1)) ? (2**COL_W - 1)
                                                                         : MAX_COLS;
  localparam logic [COL_W-1:0]   COL_LIMIT = COL_W'(COL_CAP);
  localparam logic [COL_W-1:0]   COL_MIN   = COL_W'(2);
  localparam logic [ROW_W-1:0]   ROW_MIN   = ROW_W'(2);
  localparam logic [COL_W-1:0]   COL_RESET = COL_W'(200);
  localparam logic [ROW_W-1:0]   ROW_RESET = ROW_W'(200);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(1);

  localparam logic [7:0] FLOW_NONE = 8'd0;

  // number of result slots one sample can open
  localparam int NUM_JOBS = 4;

  typedef logic signed [ELEV_BITS-1:0] elev_t;
  typedef elev_t [2:0][2:0] window_t;

  // what one sample leaves for classification once it sits in the window
  typedef struct packed {
    logic [NUM_JOBS-1:0] jobs;
    logic                top_rep;
    logic                left_rep;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
  } item_info_t;

endpackage

/* hw/rtl/d8fd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module d8fd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/d8fd_position.sv */
// Grid size registers and raster position counters; job flags for each sample.
module d8fd_position import d8fd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  step,
  output item_info_t            info,
  output logic [ADDR_W-1:0]     addr
);

  logic [COL_W-1:0] grid_cols_r, grid_cols_nxt;
  logic [ROW_W-1:0] grid_rows_r, grid_rows_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] eff_cols;
  logic [ROW_W-1:0] eff_rows;
  logic             not_first_row;
  logic             not_first_col;
  logic             last_row;
  logic             last_col;

  always_comb begin
    if (grid_cols_r < COL_MIN) begin
      eff_cols = COL_MIN;
    end else if (grid_cols_r > COL_LIMIT) begin
      eff_cols = COL_LIMIT;
    end else begin
      eff_cols = grid_cols_r;
    end
    eff_rows = (grid_rows_r < ROW_MIN) ? ROW_MIN : grid_rows_r;
  end

  assign not_first_row = (row_r >= ROW_MIN);
  assign not_first_col = (col_r >= COL_MIN);
  assign last_row      = (row_r == eff_rows);
  assign last_col      = (col_r == eff_cols);

  always_comb begin
    info.jobs[0]  = not_first_row && not_first_col;
    info.jobs[1]  = not_first_row && last_col;
    info.jobs[2]  = last_row && not_first_col;
    info.jobs[3]  = last_row && last_col;
    info.top_rep  = (row_r == ROW_MIN);
    info.left_rep = (col_r == COL_MIN);
    info.row      = row_r;
    info.col      = col_r;
  end

  assign addr = ADDR_W'(col_r - COL_W'(1));

  always_comb begin
    grid_cols_nxt = grid_cols_r;
    grid_rows_nxt = grid_rows_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    if (cfg_we && (cfg_idx == REG_GRID_COLS)) begin
      grid_cols_nxt = cfg_wdata[COL_W-1:0];
      col_nxt       = COL_W'(1);
      row_nxt       = ROW_W'(1);
    end else if (cfg_we && (cfg_idx == REG_GRID_ROWS)) begin
      grid_rows_nxt = cfg_wdata[ROW_W-1:0];
      col_nxt       = COL_W'(1);
      row_nxt       = ROW_W'(1);
    end else if (step) begin
      if (last_col) begin
        col_nxt = COL_W'(1);
        row_nxt = last_row ? ROW_W'(1) : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= COL_RESET;
      grid_rows_r <= ROW_RESET;
      col_r       <= COL_W'(1);
      row_r       <= ROW_W'(1);
    end else begin
      grid_cols_r <= grid_cols_nxt;
      grid_rows_r <= grid_rows_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
    end
  end

endmodule

/* hw/rtl/d8fd_classify.sv */
// Steepest-descent D8 classification of one cell of the 3x3 window.
module d8fd_classify import d8fd_pkg::*; (
  input  window_t    win,
  input  logic [1:0] sel,       // bit 1: centre on bottom row, bit 0: centre on right column
  input  logic       top_rep,
  input  logic       left_rep,
  output logic [7:0] code
);

  logic [1:0]                rc, cc, up, lf;
  logic [1:0]                nr [8];
  logic [1:0]                nc [8];
  elev_t                     centre;
  elev_t                     nb [8];
  logic signed [DROP_W-1:0]  drop [8];
  logic signed [SCALE_W-1:0] s [8];
  logic signed [SCALE_W-1:0] l1_s [4];
  logic [2:0]                l1_i [4];
  logic signed [SCALE_W-1:0] l2_s [2];
  logic [2:0]                l2_i [2];
  logic signed [SCALE_W-1:0] best_s;
  logic [2:0]                best_i;

  always_comb begin
    rc = sel[1] ? 2'd2 : 2'd1;
    cc = sel[0] ? 2'd2 : 2'd1;
    // replicate the edge row or column where the neighbour lies outside the raster
    up = (sel[1] || !top_rep) ? rc - 2'd1 : rc;
    lf = (sel[0] || !left_rep) ? cc - 2'd1 : cc;

    nr[0] = 2'd2; nc[0] = lf;
    nr[1] = 2'd2; nc[1] = cc;
    nr[2] = 2'd2; nc[2] = 2'd2;
    nr[3] = rc;   nc[3] = 2'd2;
    nr[4] = up;   nc[4] = 2'd2;
    nr[5] = up;   nc[5] = cc;
    nr[6] = up;   nc[6] = lf;
    nr[7] = rc;   nc[7] = lf;

    centre = win[rc][cc];
    for (int k = 0; k < 8; k++) begin
      nb[k]   = win[nr[k]][nc[k]];
      drop[k] = DROP_W'(nb[k]) - DROP_W'(centre);
      if (k % 2 == 0) begin
        s[k] = SCALE_W'(drop[k]) * SCALE_W'(DIAG_W);
      end else begin
        s[k] = SCALE_W'(drop[k]) <<< ORTH_SHIFT;
      end
    end

    // the later neighbour wins only when strictly steeper: earliest minimum survives
    for (int i = 0; i < 4; i++) begin
      if (s[2*i+1] < s[2*i]) begin
        l1_s[i] = s[2*i+1];
        l1_i[i] = 3'(2*i+1);
      end else begin
        l1_s[i] = s[2*i];
        l1_i[i] = 3'(2*i);
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (l1_s[2*i+1] < l1_s[2*i]) begin
        l2_s[i] = l1_s[2*i+1];
        l2_i[i] = l1_i[2*i+1];
      end else begin
        l2_s[i] = l1_s[2*i];
        l2_i[i] = l1_i[2*i];
      end
    end
    if (l2_s[1] < l2_s[0]) begin
      best_s = l2_s[1];
      best_i = l2_i[1];
    end else begin
      best_s = l2_s[0];
      best_i = l2_i[0];
    end

    code = (best_s < 0) ? (8'd1 << best_i) : FLOW_NONE;
  end

endmodule

/* hw/rtl/d8_flow_direction_stream.sv */
// Top level of the D8 flow-direction stream: line stores, window and result register.
//
// Elevation samples enter on the in_ channel in raster order, row by row; each
// transaction completes when in_valid and in_ready are both high. Results leave on
// the out_ channel, one transaction per cell, with the cell's row, column, D8 code
// and a frame_done flag on the final cell of the raster. Grid size is set on the
// cfg_ channel (index 0: columns, index 1: rows); cfg_ready is always high and a
// write restarts the frame at row 1, column 1.
// A sample is registered while its column is read from the two line stores, moves
// into the 3x3 window once the window has issued all its results, and each result
// is registered in the output register. Each sample yields zero to four results,
// delivered one per cycle from a single classifier while the receiver keeps up; the
// input takes one sample per cycle while each sample yields at most one result and the
// receiver keeps up; in_ready stays low while extra right-edge and last-row results issue.
// When the receiver stalls, the output register holds its result and the window and
// input register fill up behind it before in_ready drops.
// Reset (rst_n low, synchronous) clears the pipeline, the window and the position
// and sets both grid sizes to 200; the line stores need no clearing pass, as edge
// replication keeps stale entries out of every result.
module d8_flow_direction_stream import d8fd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [ELEV_BITS-1:0] in_elevation,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROW_W-1:0]      out_cell_row,
  output logic [COL_W-1:0]      out_cell_col,
  output logic [7:0]            out_flow_code,
  output logic                  out_frame_done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                  accept;
  item_info_t            pos_info;
  logic [ADDR_W-1:0]     pos_addr;

  logic                  s1_valid_r, s1_valid_nxt;
  elev_t                 s1_elev_r;
  item_info_t            s1_info_r;
  logic [ADDR_W-1:0]     s1_addr_r;

  elev_t                 rd_a, rd_b;

  window_t               win_r, win_nxt;
  item_info_t            win_info_r, win_info_nxt;

  logic                  issue;
  logic                  advance;
  logic [1:0]            job_sel;
  logic [NUM_JOBS-1:0]   pend_left;
  logic [7:0]            code;

  logic                  out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]      out_row_r;
  logic [COL_W-1:0]      out_col_r;
  logic [7:0]            out_code_r;
  logic                  out_done_r;

  assign cfg_ready = 1'b1;

  d8fd_position u_position (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .step      (accept),
    .info      (pos_info),
    .addr      (pos_addr)
  );

  // line store a holds row r-2, line store b row r-1; both rotate on advance
  d8fd_ram #(.WIDTH(ELEV_BITS), .DEPTH(MAX_COLS)) u_line_a (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_addr_r),
    .wdata (rd_b),
    .re    (accept),
    .raddr (pos_addr),
    .rdata (rd_a)
  );

  d8fd_ram #(.WIDTH(ELEV_BITS), .DEPTH(MAX_COLS)) u_line_b (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_addr_r),
    .wdata (s1_elev_r),
    .re    (accept),
    .raddr (pos_addr),
    .rdata (rd_b)
  );

  d8fd_classify u_classify (
    .win      (win_r),
    .sel      (job_sel),
    .top_rep  (win_info_r.top_rep),
    .left_rep (win_info_r.left_rep),
    .code     (code)
  );

  // pick the lowest pending result slot; release the window once the last one issues
  always_comb begin
    if (win_info_r.jobs[0]) begin
      job_sel = 2'd0;
    end else if (win_info_r.jobs[1]) begin
      job_sel = 2'd1;
    end else if (win_info_r.jobs[2]) begin
      job_sel = 2'd2;
    end else begin
      job_sel = 2'd3;
    end
    issue     = (|win_info_r.jobs) && (!out_valid_r || out_ready);
    pend_left = issue ? (win_info_r.jobs & ~(NUM_JOBS'(1) << job_sel)) : win_info_r.jobs;
    advance   = s1_valid_r && (pend_left == '0);
    in_ready  = !s1_valid_r || advance;
    accept    = in_valid && in_ready;
  end

  always_comb begin
    s1_valid_nxt = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);

    win_nxt      = win_r;
    win_info_nxt = win_info_r;
    win_info_nxt.jobs = pend_left;
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        win_nxt[k][0] = win_r[k][1];
        win_nxt[k][1] = win_r[k][2];
      end
      win_nxt[0][2] = rd_a;
      win_nxt[1][2] = rd_b;
      win_nxt[2][2] = s1_elev_r;
      win_info_nxt  = s1_info_r;
    end

    out_valid_nxt = issue ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      win_r       <= '0;
      win_info_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      win_r       <= win_nxt;
      win_info_r  <= win_info_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_elev_r <= in_elevation;
      s1_info_r <= pos_info;
      s1_addr_r <= pos_addr;
    end
    if (issue) begin
      out_row_r  <= job_sel[1] ? win_info_r.row : win_info_r.row - ROW_W'(1);
      out_col_r  <= job_sel[0] ? win_info_r.col : win_info_r.col - COL_W'(1);
      out_code_r <= code;
      out_done_r <= (job_sel == 2'd3);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_row   = out_row_r;
  assign out_cell_col   = out_col_r;
  assign out_flow_code  = out_code_r;
  assign out_frame_done = out_done_r;

endmodule
